// ===== sv/qedf_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle block.
// Holds the sequencer state type, fixed-point limits and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package qedf_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_SQ,
		ST_SQRT,
		ST_CINIT,
		ST_CITER,
		ST_CEND
	} state_t;

	localparam logic [1:0] CFG_SLOPE  = 2'd0;
	localparam logic [1:0] CFG_OFFSET = 2'd1;

	localparam logic [1:0] RUN_ROLL  = 2'd0;
	localparam logic [1:0] RUN_PITCH = 2'd1;
	localparam logic [1:0] RUN_YAW   = 2'd2;

	localparam int TAB_LEN    = 24;
	localparam int MUL_LAST   = 11;
	localparam int SQRT_ITERS = 29;

	localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
	localparam logic signed [18:0] ROLL_LIM  = 19'sd25736;
	localparam logic signed [18:0] PITCH_LIM = 19'sd12868;

	// atan(2^-i) in units of 2^-30 rad, truncated
	function automatic logic [29:0] atan_tab(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/quaternion_to_euler_drift_fix.sv =====
// Top level: quaternion to ZYX Euler angles with linear yaw drift correction.
// Shared multiplier, bit-pair square root and one shared CORDIC unit.
// Depends on qedf_pkg.
`timescale 1ns / 1ps

// Usage:
// s_axis carries one quaternion word (w, x, y, z, Q1.14) per item.
// m_axis returns one word per item: roll and drift-corrected yaw (Q3.13), pitch (Q2.13)
// and the sample index used for the correction.
// cfg carries register writes: index 0 drift slope, index 1 drift offset;
// other indexes are ignored. cfg_ready is always high.
// One item is in work at a time. s_axis_tready is high only while idle.
// Each item passes through the shared multiplier, the setup states ST_PREP and
// ST_SQ, 29 square-root steps and three CORDIC runs of CORDIC_STEPS
// iterations each; a run whose operands are both zero skips its iterations.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result holds until the receiver takes the old one.
// Reset clears the sample counter, both registers and all valid flags.
// The sample counter advances at each accept and sticks at its maximum.
module quaternion_to_euler_drift_fix #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, sample_index, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import qedf_pkg::*;

	state_t state_q, state_d;
	logic [4:0] cnt_q;
	logic [1:0] run_q;

	logic signed [31:0] slope_q;
	logic signed [15:0] offs_q;
	logic [31:0] smp_q;

	logic signed [15:0] w_q, x_q, y_q, z_q;
	logic [31:0] n_q;

	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_s1;
	logic signed [32:0] mp;

	logic signed [32:0] sra_q, srb_q, spa_q, sya_q, syb_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] ra_q, rb_q, ya_q, yb_q;
	logic signed [29:0] pa_q;
	logic signed [33:0] pa2;

	logic [57:0] v_q;
	logic [29:0] rem_q;
	logic [28:0] root_q;
	logic [31:0] rem_n, trial;

	logic signed [36:0] cx_q, cy_q, selx, sely, xs, ys;
	logic signed [35:0] cz_q, zr_q, zp_q;
	logic sel_zero;

	logic out_free;
	logic signed [18:0] roll_r, pitch_r;
	logic signed [15:0] roll_c;
	logic signed [14:0] pitch_c;
	logic signed [43:0] yaw_sum;
	logic signed [24:0] yaw_r;
	logic signed [15:0] yaw_c;

	logic        mv_q;
	logic [79:0] mdata_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_axis_tvalid) state_d = ST_MUL;
			ST_MUL:   if (cnt_q == 5'(MUL_LAST)) state_d = ST_PREP;
			ST_PREP:  state_d = ST_SQ;
			ST_SQ:    state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == 5'(SQRT_ITERS - 1)) state_d = ST_CINIT;
			ST_CINIT: state_d = sel_zero ? ST_CEND : ST_CITER;
			ST_CITER: if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = ST_CEND;
			ST_CEND: begin
				if (run_q == RUN_YAW) begin
					if (out_free) state_d = ST_IDLE;
				end else begin
					state_d = ST_CINIT;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		cfg_ready     = 1'b1;
		m_axis_tvalid = mv_q;
		m_axis_tdata  = mdata_q;
	end

	assign out_free = !mv_q || m_axis_tready;

	// shared multiplier operand select
	always_comb begin
		mul_a = 33'sd0;
		mul_b = 18'sd0;
		case (cnt_q)
			5'd0:  begin mul_a = 33'(w_q); mul_b = 18'(x_q); end
			5'd1:  begin mul_a = 33'(y_q); mul_b = 18'(z_q); end
			5'd2:  begin mul_a = 33'(x_q); mul_b = 18'(x_q); end
			5'd3:  begin mul_a = 33'(y_q); mul_b = 18'(y_q); end
			5'd4:  begin mul_a = 33'(w_q); mul_b = 18'(y_q); end
			5'd5:  begin mul_a = 33'(z_q); mul_b = 18'(x_q); end
			5'd6:  begin mul_a = 33'(w_q); mul_b = 18'(z_q); end
			5'd7:  begin mul_a = 33'(x_q); mul_b = 18'(y_q); end
			5'd8:  begin mul_a = 33'(z_q); mul_b = 18'(z_q); end
			5'd9:  begin mul_a = 33'(slope_q); mul_b = $signed({2'b00, n_q[15:0]}); end
			5'd10: begin mul_a = 33'(slope_q); mul_b = $signed({2'b00, n_q[31:16]}); end
			default: begin mul_a = 33'sd0; mul_b = 18'sd0; end
		endcase
	end

	assign mp    = $signed(mul_s1[32:0]);
	assign pa2   = 34'sd2 * {{1{spa_q[32]}}, spa_q};
	assign rem_n = {rem_q, v_q[57:56]};
	assign trial = {1'b0, root_q, 2'b01};

	// CORDIC operand select
	always_comb begin
		case (run_q)
			RUN_ROLL:  begin selx = 37'(rb_q); sely = 37'(ra_q); end
			RUN_PITCH: begin selx = $signed({8'd0, root_q}); sely = 37'(pa_q); end
			default:   begin selx = 37'(yb_q); sely = 37'(ya_q); end
		endcase
		sel_zero = (selx == 37'sd0) && (sely == 37'sd0);
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
	end

	// final rounding and saturation
	always_comb begin
		roll_r = 19'((zr_q + 36'sd65536) >>> 17);
		if (roll_r > ROLL_LIM) roll_r = ROLL_LIM;
		if (roll_r < -ROLL_LIM) roll_r = -ROLL_LIM;
		roll_c = 16'(roll_r);
		pitch_r = 19'((zp_q + 36'sd65536) >>> 17);
		if (pitch_r > PITCH_LIM) pitch_r = PITCH_LIM;
		if (pitch_r < -PITCH_LIM) pitch_r = -PITCH_LIM;
		pitch_c = 15'(pitch_r);
		yaw_sum = 44'(cz_q) * 44'sd4 - (44'(offs_q) <<< 19) - 44'(prod_q);
		yaw_r = 25'((yaw_sum + 44'sd262144) >>> 19);
		if (prod_q > 64'sd1099511627776) begin
			yaw_c = -16'sd32768;
		end else if (prod_q < -64'sd1099511627776) begin
			yaw_c = 16'sd32767;
		end else if (yaw_r > 25'sd32767) begin
			yaw_c = 16'sd32767;
		end else if (yaw_r < -25'sd32768) begin
			yaw_c = -16'sd32768;
		end else begin
			yaw_c = 16'(yaw_r);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 5'd0;
			run_q   <= RUN_ROLL;
			slope_q <= 32'sd0;
			offs_q  <= 16'sd0;
			smp_q   <= 32'd0;
			mv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (cfg_valid) begin
				if (cfg_index == CFG_SLOPE) slope_q <= $signed(cfg_data);
				if (cfg_index == CFG_OFFSET) offs_q <= $signed(cfg_data[15:0]);
			end
			if (state_q == ST_IDLE && s_axis_tvalid && smp_q != 32'hFFFFFFFF)
				smp_q <= smp_q + 32'd1;
			if (state_q == ST_IDLE) run_q <= RUN_ROLL;
			if (state_q == ST_CEND && run_q != RUN_YAW) run_q <= run_q + 2'd1;
			if (state_q == ST_CEND && run_q == RUN_YAW && out_free)
				mv_q <= 1'b1;
			else if (m_axis_tready)
				mv_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_s1 <= 51'(mul_a * mul_b);
		case (state_q)
			ST_IDLE: begin
				w_q <= $signed(s_axis_tdata[15:0]);
				x_q <= $signed(s_axis_tdata[31:16]);
				y_q <= $signed(s_axis_tdata[47:32]);
				z_q <= $signed(s_axis_tdata[63:48]);
				n_q <= smp_q;
				sra_q <= 33'sd0;
				srb_q <= 33'sd0;
				spa_q <= 33'sd0;
				sya_q <= 33'sd0;
				syb_q <= 33'sd0;
			end
			ST_MUL: begin
				case (cnt_q)
					5'd1:  sra_q <= sra_q + mp;
					5'd2:  sra_q <= sra_q + mp;
					5'd3:  srb_q <= srb_q + mp;
					5'd4: begin
						srb_q <= srb_q + mp;
						syb_q <= syb_q + mp;
					end
					5'd5:  spa_q <= spa_q + mp;
					5'd6:  spa_q <= spa_q - mp;
					5'd7:  sya_q <= sya_q + mp;
					5'd8:  sya_q <= sya_q + mp;
					5'd9:  syb_q <= syb_q + mp;
					5'd10: prod_q <= 64'(mul_s1);
					5'd11: prod_q <= prod_q + (64'(mul_s1) <<< 16);
					default: ;
				endcase
			end
			ST_PREP: begin
				ra_q <= 34'sd2 * 34'(sra_q);
				rb_q <= 34'sd268435456 - 34'sd2 * 34'(srb_q);
				ya_q <= 34'sd2 * 34'(sya_q);
				yb_q <= 34'sd268435456 - 34'sd2 * 34'(syb_q);
				if (pa2 > 34'sd268435456) pa_q <= 30'sd268435456;
				else if (pa2 < -34'sd268435456) pa_q <= -30'sd268435456;
				else pa_q <= 30'(pa2);
			end
			ST_SQ: begin
				v_q    <= (58'd1 << 56) - 58'(pa_q * pa_q);
				rem_q  <= 30'd0;
				root_q <= 29'd0;
			end
			ST_SQRT: begin
				v_q <= v_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= 30'(rem_n - trial);
					root_q <= {root_q[27:0], 1'b1};
				end else begin
					rem_q  <= 30'(rem_n);
					root_q <= {root_q[27:0], 1'b0};
				end
			end
			ST_CINIT: begin
				if (sel_zero) begin
					cz_q <= 36'sd0;
				end else if (selx < 37'sd0) begin
					cz_q <= (sely >= 37'sd0) ? PI_Q30 : -PI_Q30;
					cx_q <= -selx;
					cy_q <= -sely;
				end else begin
					cz_q <= 36'sd0;
					cx_q <= selx;
					cy_q <= sely;
				end
			end
			ST_CITER: begin
				if (cy_q > 37'sd0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + $signed({6'd0, atan_tab(cnt_q)});
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - $signed({6'd0, atan_tab(cnt_q)});
				end
			end
			ST_CEND: begin
				case (run_q)
					RUN_ROLL:  zr_q <= cz_q;
					RUN_PITCH: zp_q <= cz_q;
					default:   ;
				endcase
			end
			default: ;
		endcase
		if (state_q == ST_CEND && run_q == RUN_YAW && out_free)
			mdata_q <= {1'b0, n_q, yaw_c, pitch_c, roll_c};
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !$past(s_axis_tready) || state_q == ST_IDLE)
		else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled word changed");
	a_smp_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=>
		smp_q == $past(smp_q) + 32'd1 || $past(smp_q) == 32'hFFFFFFFF)
		else $error("sample counter slip");
	a_zy_unused: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == ST_MUL && cnt_q == 5'd0)
		else $error("accept did not start work");
`endif

endmodule

// ===== tb/quaternion_to_euler_drift_fix_tb.sv =====
// Testbench for quaternion_to_euler_drift_fix: directed and random quaternion words,
// drift register phases, random stalls on both streams, checked against a built-in predictor.
// Depends on qedf_pkg and the block's top level.
`timescale 1ns / 1ps

class euler_scoreboard;
	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic [31:0]        index;
	} angles_t;

	localparam longint ONE_Q28 = 64'sd268435456;
	localparam longint PI_Q30  = 64'sd3373259426;
	localparam int     STEPS   = 16;

	longint  atan_step[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
	angles_t     pending[$];
	logic [31:0] drift_slope;
	logic [15:0] drift_offset;
	logic [31:0] samples_seen;
	int          mismatches;

	function new();
		drift_slope  = '0;
		drift_offset = '0;
		samples_seen = '0;
		mismatches   = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		if (idx == qedf_pkg::CFG_SLOPE)
			drift_slope = val;
		else if (idx == qedf_pkg::CFG_OFFSET)
			drift_offset = val[15:0];
	endfunction

	function longint vector_angle(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q30 : -PI_Q30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += atan_step[i];
			end else begin
				x -= ys;
				y += xs;
				z -= atan_step[i];
			end
		end
		return z;
	endfunction

	function longint to_q13(longint z, longint lim);
		longint r;
		r = (z + 65536) >>> 17;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function longint floor_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function void note_quaternion(logic [63:0] word);
		longint w, x, y, z, ra, rb, pa, pc, ya, yb, prod, r, yaw, slope, offs;
		angles_t a;
		w = longint'($signed(word[15:0]));
		x = longint'($signed(word[31:16]));
		y = longint'($signed(word[47:32]));
		z = longint'($signed(word[63:48]));
		slope = longint'($signed(drift_slope));
		offs  = longint'($signed(drift_offset));
		ra = 2 * (w * x + y * z);
		rb = ONE_Q28 - 2 * (x * x + y * y);
		a.roll = 16'(to_q13(vector_angle(ra, rb), 25736));
		pa = 2 * (w * y - z * x);
		if (pa > ONE_Q28) pa = ONE_Q28;
		if (pa < -ONE_Q28) pa = -ONE_Q28;
		pc = floor_sqrt(longint'(ONE_Q28 * ONE_Q28) - pa * pa);
		a.pitch = 15'(to_q13(vector_angle(pa, pc), 12868));
		ya = 2 * (w * z + x * y);
		yb = ONE_Q28 - 2 * (y * y + z * z);
		prod = slope * longint'({32'd0, samples_seen});
		if (prod > (64'sd1 <<< 40))
			yaw = -32768;
		else if (prod < -(64'sd1 <<< 40))
			yaw = 32767;
		else begin
			r = vector_angle(ya, yb) * 4 - offs * 524288 - prod;
			yaw = (r + 262144) >>> 19;
			if (yaw > 32767) yaw = 32767;
			if (yaw < -32768) yaw = -32768;
		end
		a.yaw = 16'(yaw);
		a.index = samples_seen;
		if (samples_seen != 32'hFFFF_FFFF)
			samples_seen++;
		pending.push_back(a);
	endfunction

	function void check_result(logic [79:0] word);
		angles_t e;
		if (pending.size() == 0) begin
			$error("unexpected result word %h", word);
			mismatches++;
			return;
		end
		e = pending.pop_front();
		if (word[15:0] !== e.roll) begin
			$error("roll_angle expected %0d actual %0d", e.roll, $signed(word[15:0]));
			mismatches++;
		end
		if (word[30:16] !== e.pitch) begin
			$error("pitch_angle expected %0d actual %0d", e.pitch, $signed(word[30:16]));
			mismatches++;
		end
		if (word[46:31] !== e.yaw) begin
			$error("yaw_angle expected %0d actual %0d", e.yaw, $signed(word[46:31]));
			mismatches++;
		end
		if (word[78:47] !== e.index) begin
			$error("sample_index expected %0d actual %0d", e.index, word[78:47]);
			mismatches++;
		end
	endfunction
endclass

module quaternion_to_euler_drift_fix_tb;
	import qedf_pkg::*;

	localparam logic [1:0] CFG_SPARE2 = 2'd2;
	localparam logic [1:0] CFG_SPARE3 = 2'd3;
	localparam int SETTLE = 120;
	localparam int WATCHDOG = 5000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	euler_scoreboard sb;
	bit hold_off;
	int quiet_cycles;

	quaternion_to_euler_drift_fix dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls, long hold-off on request, stretches with none
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			if ($urandom_range(0, 9) < 2) begin
				m_axis_tready = 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end
			gap = pick_gap();
			m_axis_tready = (gap == 0);
			if (gap > 0)
				repeat (gap - 1) @(negedge clk);
		end
	end

	task automatic send_quat(input logic [15:0] w, x, y, z, input bit busy);
		int gap;
		gap = busy ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  = {z, y, x, w};
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_quaternion(s_axis_tdata);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [15:0] edge_comp();
		case ($urandom_range(0, 4))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'd0;
			3: return 16'($urandom_range(0, 1) ? 16383 : -16383);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	task automatic random_quats(input int count, input bit busy);
		real a[4], nrm;
		logic [15:0] q[4];
		int r;
		repeat (count) begin
			r = $urandom_range(0, 99);
			for (int i = 0; i < 4; i++) begin
				a[i] = real'($urandom_range(0, 32768)) - 16384.0;
				q[i] = 16'($rtoi(a[i]));
			end
			if (r < 70) begin
				nrm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
				if (nrm > 1.0)
					for (int i = 0; i < 4; i++)
						q[i] = 16'($rtoi(a[i] * 16384.0 / nrm));
			end else if (r < 85) begin
				for (int i = 0; i < 4; i++)
					q[i] = edge_comp();
			end
			send_quat(q[0], q[1], q[2], q[3], busy);
		end
	endtask

	initial begin
		sb = new();
		hold_off = 1'b0;
		quiet_cycles = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SLOPE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity, extremes, zero atan operands, pi branch, asin clamp, non-unit
		send_quat(16'sd16384, 0, 0, 0, 0);
		send_quat(-16'sd16384, 0, 0, 0, 0);
		send_quat(0, 16'sd16384, 0, 0, 0);
		send_quat(0, 0, 16'sd16384, 0, 0);
		send_quat(0, 0, 0, 16'sd16384, 0);
		send_quat(0, 0, 0, -16'sd16384, 0);
		send_quat(0, 16'sd8192, 16'sd8192, 0, 0);
		send_quat(0, 0, 16'sd8192, 16'sd8192, 0);
		send_quat(0, 0, 0, 0, 0);
		send_quat(16'sd16384, 0, 16'sd16384, 0, 0);
		send_quat(16'sd16384, 0, -16'sd16384, 0, 0);
		send_quat(16'sd11585, 0, 16'sd11585, 0, 0);
		send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
		send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
		send_quat(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 0);
		send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 0);
		send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1, 0);
		send_quat(0, 16'sd11585, 0, -16'sd11585, 0);
		// fill the block while the receiver holds off
		hold_off = 1'b1;
		random_quats(8, 1);
		random_quats(150, 0);
		drain();

		write_reg(CFG_SLOPE, $urandom);
		write_reg(CFG_OFFSET, $urandom);
		random_quats(200, 0);
		drain();

		write_reg(CFG_SLOPE, 32'($signed($urandom_range(0, 20000)) - 10000));
		write_reg(CFG_OFFSET, 32'($signed($urandom_range(0, 2000)) - 1000));
		hold_off = 1'b1;
		random_quats(200, 1);
		drain();

		write_reg(CFG_SLOPE, 32'h7FFF_FFFF);
		write_reg(CFG_OFFSET, 32'h0000_7FFF);
		random_quats(250, 0);
		drain();

		write_reg(CFG_SLOPE, 32'h8000_0000);
		write_reg(CFG_OFFSET, 32'h0000_8000);
		random_quats(250, 0);
		drain();

		write_reg(CFG_SPARE2, $urandom);
		write_reg(CFG_SPARE3, $urandom);
		write_reg(CFG_SLOPE, 32'($signed($urandom_range(0, 4000000)) - 2000000));
		write_reg(CFG_OFFSET, 32'hFFFF_FFFF);
		random_quats(230, 0);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== quaternion_to_euler_drift_fix.f =====
sv/qedf_pkg.sv
sv/quaternion_to_euler_drift_fix.sv
tb/quaternion_to_euler_drift_fix_tb.sv
